FILE: sv/pipc_pkg.sv
package pipc_pkg;

  // Field widths
  localparam int TEMP_W  = 12;
  localparam int ERR_W   = TEMP_W + 1;
  localparam int GAIN_W  = 8;
  localparam int POWER_W = 16;
  localparam int INTEG_W = 16;
  localparam int TICK_W  = 16;
  localparam int MARGIN_W = 8;

  // Stream word widths
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 24;

  // Config port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PROP_GAIN      = 3'd0,
    CFG_INTEG_GAIN     = 3'd1,
    CFG_INTEG_INTERVAL = 3'd2,
    CFG_POWER_MAX      = 3'd3,
    CFG_POWER_MIN      = 3'd4,
    CFG_CUTOFF_MARGIN  = 3'd5
  } cfg_idx_t;

  // Reset values of the registers and of the last output
  localparam logic [GAIN_W-1:0]   RST_PROP_GAIN      = 8'd50;
  localparam logic [GAIN_W-1:0]   RST_INTEG_GAIN     = 8'd20;
  localparam logic [TICK_W-1:0]   RST_INTEG_INTERVAL = 16'd20;
  localparam logic [POWER_W-1:0]  RST_POWER_MAX      = 16'd7500;
  localparam logic [POWER_W-1:0]  RST_POWER_MIN      = 16'd500;
  localparam logic [MARGIN_W-1:0] RST_CUTOFF_MARGIN  = 8'd20;
  localparam logic [POWER_W-1:0]  RST_LAST_POWER     = 16'd500;

  typedef struct packed {
    logic [GAIN_W-1:0]   prop_gain;
    logic [GAIN_W-1:0]   integ_gain;
    logic [TICK_W-1:0]   integ_interval;
    logic [POWER_W-1:0]  power_max;
    logic [POWER_W-1:0]  power_min;
    logic [MARGIN_W-1:0] cutoff_margin;
  } cfg_regs_t;

  typedef struct packed {
    logic [POWER_W-1:0] drive_power;
    logic               cutoff_active;
  } result_t;

endpackage

FILE: sv/pi_power_controller.sv
// Each accepted input word is held in the input register and its result in the result
// register, where it waits on out_tready.
// Throughput: one word per cycle; the input side stalls only while a result waits on
// out_tready with the input register also full.
// Reset: synchronous active-low rst_n empties both stages, loads the register reset values,
// clears the integral and tick counter and sets the last output to 500.
module pi_power_controller (
  input  logic                                clk,
  input  logic                                rst_n,
  // in_tdata: [11:0] target_temp, [23:12] measured_temp
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [pipc_pkg::IN_DATA_W-1:0]      in_tdata,
  // out_tdata: [15:0] drive_power, [16] cutoff_active, [23:17] zero
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [pipc_pkg::OUT_DATA_W-1:0]     out_tdata,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [pipc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pipc_pkg::CFG_DATA_W-1:0]     cfg_data
);

  pipc_pkg::cfg_regs_t cfg;
  pipc_pkg::result_t   res;

  logic                                      s1_valid_r;
  logic signed [pipc_pkg::TEMP_W-1:0]        target_r;
  logic signed [pipc_pkg::TEMP_W-1:0]        measured_r;
  logic                                      out_valid_r;
  logic [pipc_pkg::OUT_DATA_W-1:0]           out_data_r;
  logic                                      s1_go;
  logic                                      in_take;

  assign cfg_ready = 1'b1;

  pipc_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // Handshake: stage 1 moves on when the result register is free or being drained
  assign s1_go     = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_go;
  assign in_take   = in_tvalid && in_tready;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      target_r   <= in_tdata[pipc_pkg::TEMP_W-1:0];
      measured_r <= in_tdata[2*pipc_pkg::TEMP_W-1:pipc_pkg::TEMP_W];
    end
  end

  pipc_law u_law (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (s1_go),
    .target_temp   (target_r),
    .measured_temp (measured_r),
    .cfg           (cfg),
    .res           (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      out_data_r <= {{(pipc_pkg::OUT_DATA_W-pipc_pkg::POWER_W-1){1'b0}},
                     res.cutoff_active, res.drive_power};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

FILE: sv/pipc_cfg_regs.sv
module pipc_cfg_regs (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                wr_en,
  input  logic [pipc_pkg::CFG_IDX_W-1:0]      wr_index,
  input  logic [pipc_pkg::CFG_DATA_W-1:0]     wr_data,
  output pipc_pkg::cfg_regs_t                 cfg
);

  pipc_pkg::cfg_regs_t cfg_r, cfg_nxt;

  // Register write decode; unknown indexes are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (wr_index)
        pipc_pkg::CFG_PROP_GAIN:
          cfg_nxt.prop_gain = wr_data[pipc_pkg::GAIN_W-1:0];
        pipc_pkg::CFG_INTEG_GAIN:
          cfg_nxt.integ_gain = wr_data[pipc_pkg::GAIN_W-1:0];
        pipc_pkg::CFG_INTEG_INTERVAL:
          cfg_nxt.integ_interval = wr_data[pipc_pkg::TICK_W-1:0];
        pipc_pkg::CFG_POWER_MAX:
          cfg_nxt.power_max = wr_data[pipc_pkg::POWER_W-1:0];
        pipc_pkg::CFG_POWER_MIN:
          cfg_nxt.power_min = wr_data[pipc_pkg::POWER_W-1:0];
        pipc_pkg::CFG_CUTOFF_MARGIN:
          cfg_nxt.cutoff_margin = wr_data[pipc_pkg::MARGIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.prop_gain      <= pipc_pkg::RST_PROP_GAIN;
      cfg_r.integ_gain     <= pipc_pkg::RST_INTEG_GAIN;
      cfg_r.integ_interval <= pipc_pkg::RST_INTEG_INTERVAL;
      cfg_r.power_max      <= pipc_pkg::RST_POWER_MAX;
      cfg_r.power_min      <= pipc_pkg::RST_POWER_MIN;
      cfg_r.cutoff_margin  <= pipc_pkg::RST_CUTOFF_MARGIN;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: sv/pipc_law.sv
module pipc_law (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                step,
  input  logic signed [pipc_pkg::TEMP_W-1:0]  target_temp,
  input  logic signed [pipc_pkg::TEMP_W-1:0]  measured_temp,
  input  pipc_pkg::cfg_regs_t                 cfg,
  output pipc_pkg::result_t                   res
);

  localparam int PROD_P_W = pipc_pkg::ERR_W + pipc_pkg::GAIN_W + 1;
  localparam int PROD_I_W = pipc_pkg::INTEG_W + pipc_pkg::GAIN_W + 1;
  localparam int RAW_W    = PROD_I_W + 1;
  localparam int SUM_W    = pipc_pkg::INTEG_W + 1;

  logic signed [pipc_pkg::INTEG_W-1:0] integral_r, integral_nxt;
  logic        [pipc_pkg::TICK_W-1:0]  tick_r, tick_nxt;
  logic        [pipc_pkg::POWER_W-1:0] last_power_r;

  logic signed [pipc_pkg::ERR_W-1:0]  err;
  logic signed [pipc_pkg::ERR_W-1:0]  neg_margin;
  logic                               match;
  logic                               gate_open;
  logic signed [SUM_W-1:0]            sum;
  logic signed [PROD_P_W-1:0]         prod_p;
  logic signed [PROD_I_W-1:0]         prod_i;
  logic signed [RAW_W-1:0]            raw;
  logic signed [RAW_W-1:0]            lim_max;
  logic signed [RAW_W-1:0]            lim_min;
  logic                               cutoff;
  logic        [pipc_pkg::POWER_W-1:0] power;

  // Error, 13-bit signed
  assign err = pipc_pkg::ERR_W'(target_temp) - pipc_pkg::ERR_W'(measured_temp);

  // Tick counter: integrate on every (interval + 1)-th tick
  assign match    = (tick_r == cfg.integ_interval);
  assign tick_nxt = match ? '0 : tick_r + 1'b1;

  // Anti-windup gate on the previous output
  assign gate_open = (last_power_r > cfg.power_min) && (last_power_r < cfg.power_max);

  // Saturating integral update
  assign sum = SUM_W'(integral_r) + SUM_W'(err);
  always_comb begin
    integral_nxt = integral_r;
    if (match && gate_open) begin
      if (sum > SUM_W'(32767))
        integral_nxt = 16'sh7FFF;
      else if (sum < -SUM_W'(32768))
        integral_nxt = 16'sh8000;
      else
        integral_nxt = sum[pipc_pkg::INTEG_W-1:0];
    end
  end

  // PI law on the updated integral
  assign prod_p = PROD_P_W'($signed({1'b0, cfg.prop_gain})) * PROD_P_W'(err);
  assign prod_i = PROD_I_W'($signed({1'b0, cfg.integ_gain})) * PROD_I_W'(integral_nxt);
  assign raw    = RAW_W'(prod_p) + RAW_W'(prod_i);

  // Over-temperature cutoff and clamp
  assign neg_margin = -$signed({{(pipc_pkg::ERR_W-pipc_pkg::MARGIN_W){1'b0}},
                                cfg.cutoff_margin});
  assign cutoff  = (err < neg_margin);
  assign lim_max = $signed({{(RAW_W-pipc_pkg::POWER_W){1'b0}}, cfg.power_max});
  assign lim_min = $signed({{(RAW_W-pipc_pkg::POWER_W){1'b0}}, cfg.power_min});

  always_comb begin
    if (cutoff) begin
      if (lim_min > lim_max)
        power = cfg.power_max;
      else
        power = cfg.power_min;
    end else if (raw > lim_max) begin
      power = cfg.power_max;
    end else if (raw < lim_min) begin
      power = cfg.power_min;
    end else begin
      power = raw[pipc_pkg::POWER_W-1:0];
    end
  end

  assign res.drive_power   = power;
  assign res.cutoff_active = cutoff;

  // Controller state advances once per word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integral_r   <= '0;
      tick_r       <= '0;
      last_power_r <= pipc_pkg::RST_LAST_POWER;
    end else if (step) begin
      integral_r   <= integral_nxt;
      tick_r       <= tick_nxt;
      last_power_r <= power;
    end
  end

endmodule

FILE: sv/pipc_checker.sv
module pipc_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_tready,
  input logic                                out_tvalid,
  input logic                                out_tready,
  input logic [pipc_pkg::OUT_DATA_W-1:0]     out_tdata
);

  // Reset empties the result register
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("out_tvalid high after reset");

  // Input side stalls only behind a blocked result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_tvalid && !out_tready))
    else $error("in_tready low without a blocked result");

  // Pad bits of the result word stay zero
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[pipc_pkg::OUT_DATA_W-1:pipc_pkg::POWER_W+1] == '0))
    else $error("nonzero pad bits in out_tdata");

  // Stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("result word changed while stalled");

endmodule

bind pi_power_controller pipc_checker u_pipc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
